### hw/rtl/column_max_brightness_tracker_core_defines.svh
// assertion macros for the column max brightness tracker
`ifndef COLUMN_MAX_BRIGHTNESS_TRACKER_CORE_DEFINES_SVH
`define COLUMN_MAX_BRIGHTNESS_TRACKER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CMBT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("cmbt assertion failed");
`define CMBT_ASSERT_NEVER(lbl, prop) `CMBT_ASSERT(lbl, !(prop))
`else
`define CMBT_ASSERT(lbl, prop)
`define CMBT_ASSERT_NEVER(lbl, prop)
`endif
`endif

### hw/rtl/cmbt_pkg.sv
// shared types and constants of the column max brightness tracker
`default_nettype none
package cmbt_pkg;

  localparam int unsigned COLUMNS    = 1024;
  localparam int unsigned ADDR_W     = $clog2(COLUMNS);
  localparam int unsigned COL_W      = 10;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned NORM_W     = 18;
  localparam int unsigned COLOUR_W   = 3 * CHAN_W;
  localparam int unsigned ENTRY_W    = NORM_W + COLOUR_W;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;

  localparam logic [CHAN_W-1:0] SAT_LEVEL = 8'd255;

  typedef enum logic {
    CMD_ACCUM = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } clr_state_e;

  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   addr;
    logic [ENTRY_W-1:0]  data;
  } mem_wr_t;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic              sat;
  } result_t;

endpackage
`default_nettype wire

### hw/rtl/cmbt_ram.sv
// generic simple dual port ram with registered read
`default_nettype none
module cmbt_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 42
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### hw/rtl/cmbt_fifo.sv
// small result queue between the update stage and the output channel
`default_nettype none
module cmbt_fifo import cmbt_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire result_t               push_data_i,
  input  wire logic                  pop_i,
  output logic                       valid_o,
  output result_t                    data_o,
  output logic      [FIFO_CNT_W-1:0] count_o
);

  result_t               buf_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + FIFO_CNT_W'(push_i) - FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = count_q != '0;
  assign data_o  = buf_q[rd_ptr_q];
  assign count_o = count_q;

endmodule
`default_nettype wire

### hw/rtl/cmbt_rmw.sv
// norm calculation, read-modify-write of the column entry and result forming
`default_nettype none
module cmbt_rmw import cmbt_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_fire_i,
  input  wire cmd_e                 cmd_i,
  input  wire logic [COL_W-1:0]     column_i,
  input  wire logic [CHAN_W-1:0]    blue_i,
  input  wire logic [CHAN_W-1:0]    green_i,
  input  wire logic [CHAN_W-1:0]    red_i,
  input  wire logic [ENTRY_W-1:0]   rdata_i,
  output mem_wr_t                   wr_o,
  output logic                      push_o,
  output result_t                   res_o,
  output logic                      pend_o
);

  logic [2*CHAN_W-1:0] bb, gg, rr;
  logic [NORM_W-1:0]   norm;

  logic                s1_valid_q;
  cmd_e                s1_cmd_q;
  logic [COL_W-1:0]    s1_col_q;
  logic                s1_in_range_q;
  logic [NORM_W-1:0]   s1_norm_q;
  logic [COLOUR_W-1:0] s1_colour_q;
  mem_wr_t             fwd_q;

  logic [ENTRY_W-1:0]  cur;
  logic [NORM_W-1:0]   cur_norm;
  logic [CHAN_W-1:0]   cur_b, cur_g, cur_r, stripe;
  logic                sat;
  mem_wr_t             wr;

  always_comb begin
    bb   = blue_i * blue_i;
    gg   = green_i * green_i;
    rr   = red_i * red_i;
    norm = NORM_W'(bb) + NORM_W'(gg) + NORM_W'(rr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= '0;
    end else begin
      s1_valid_q <= in_fire_i;
      fwd_q      <= wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      s1_cmd_q      <= cmd_i;
      s1_col_q      <= column_i;
      s1_in_range_q <= 32'(column_i) < COLUMNS;
      s1_norm_q     <= norm;
      s1_colour_q   <= {blue_i, green_i, red_i};
    end
  end

  // previous write lands in the same edge as this read
  always_comb begin
    cur      = (fwd_q.en && fwd_q.addr == ADDR_W'(s1_col_q)) ? fwd_q.data : rdata_i;
    cur_norm = cur[ENTRY_W-1 -: NORM_W];
    cur_b    = cur[3*CHAN_W-1 -: CHAN_W];
    cur_g    = cur[2*CHAN_W-1 -: CHAN_W];
    cur_r    = cur[CHAN_W-1:0];
  end

  always_comb begin
    wr.en   = 1'b0;
    wr.addr = ADDR_W'(s1_col_q);
    wr.data = '0;
    if (s1_valid_q && s1_in_range_q) begin
      unique case (s1_cmd_q)
        CMD_ACCUM: begin
          wr.en   = s1_norm_q > cur_norm;
          wr.data = {s1_norm_q, s1_colour_q};
        end
        CMD_READ: begin
          wr.en = 1'b1;
        end
        default: begin
          wr.en = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    stripe       = s1_col_q[0] ? SAT_LEVEL : '0;
    sat          = s1_in_range_q &&
                   (cur_b == SAT_LEVEL || cur_g == SAT_LEVEL || cur_r == SAT_LEVEL);
    res_o.column = s1_col_q;
    res_o.sat    = sat;
    if (!s1_in_range_q) begin
      res_o.blue  = '0;
      res_o.green = '0;
      res_o.red   = '0;
    end else if (sat) begin
      res_o.blue  = stripe;
      res_o.green = stripe;
      res_o.red   = stripe;
    end else begin
      res_o.blue  = cur_b;
      res_o.green = cur_g;
      res_o.red   = cur_r;
    end
  end

  assign wr_o   = wr;
  assign pend_o = s1_valid_q && (s1_cmd_q == CMD_READ);
  assign push_o = pend_o;

endmodule
`default_nettype wire

### hw/rtl/column_max_brightness_tracker_core.sv
// top level of the column max brightness tracker
// a read transaction's result passes the rmw stage register and the result fifo before it reaches the output
// throughput: one transaction per cycle, set by the ram read-modify-write with
// forwarding; after clearing, input stalls only when queued plus in-flight results
// reach four; reset: a clearing pass writes all COLUMNS ram entries, one per cycle,
// and no transaction is accepted until it finishes
`default_nettype none
`include "column_max_brightness_tracker_core_defines.svh"
module column_max_brightness_tracker_core import cmbt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              cmd_i,
  input  wire logic [COL_W-1:0]  column_i,
  input  wire logic [CHAN_W-1:0] blue_i,
  input  wire logic [CHAN_W-1:0] green_i,
  input  wire logic [CHAN_W-1:0] red_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [COL_W-1:0]  out_column_o,
  output logic      [CHAN_W-1:0] out_blue_o,
  output logic      [CHAN_W-1:0] out_green_o,
  output logic      [CHAN_W-1:0] out_red_o,
  output logic                   saturated_o
);

  clr_state_e            state_q, state_d;
  logic [ADDR_W-1:0]     clr_addr_q, clr_addr_d;
  logic                  clr_wr_en;

  logic                  in_fire;
  logic [ENTRY_W-1:0]    rdata;
  mem_wr_t               rmw_wr, mem_wr;
  logic                  push, pend;
  result_t               push_res, out_res;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W:0]   backlog;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == ADDR_W'(COLUMNS - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        state_d = ST_RUN;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    clr_wr_en  = 1'b0;
    clr_addr_d = clr_addr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_wr_en  = 1'b1;
        clr_addr_d = clr_addr_q + 1'b1;
      end
      ST_RUN: begin
        clr_wr_en = 1'b0;
      end
      default: begin
        clr_wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign backlog    = (FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(pend);
  assign in_ready_o = (state_q == ST_RUN) && (backlog < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    if (clr_wr_en) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = clr_addr_q;
      mem_wr.data = '0;
    end else begin
      mem_wr = rmw_wr;
    end
  end

  cmbt_ram #(
    .Depth (COLUMNS),
    .Width (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_wr.en),
    .waddr_i (mem_wr.addr),
    .wdata_i (mem_wr.data),
    .raddr_i (ADDR_W'(column_i)),
    .rdata_o (rdata)
  );

  cmbt_rmw u_rmw (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .cmd_i     (cmd_e'(cmd_i)),
    .column_i  (column_i),
    .blue_i    (blue_i),
    .green_i   (green_i),
    .red_i     (red_i),
    .rdata_i   (rdata),
    .wr_o      (rmw_wr),
    .push_o    (push),
    .res_o     (push_res),
    .pend_o    (pend)
  );

  cmbt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_res),
    .pop_i       (out_ready_i),
    .valid_o     (out_valid_o),
    .data_o      (out_res),
    .count_o     (fifo_count)
  );

  assign out_column_o = out_res.column;
  assign out_blue_o   = out_res.blue;
  assign out_green_o  = out_res.green;
  assign out_red_o    = out_res.red;
  assign saturated_o  = out_res.sat;

  `CMBT_ASSERT_NEVER(a_clear_rmw_overlap, clr_wr_en && rmw_wr.en)
  `CMBT_ASSERT(a_no_accept_in_clear, (state_q == ST_CLEAR) |-> !in_ready_o)
  `CMBT_ASSERT(a_backlog_bound, backlog <= (FIFO_CNT_W + 1)'(FIFO_DEPTH))

endmodule
`default_nettype wire

### bench/cmbt_peak_checker.sv
// per-column peak brightness model that predicts read results and checks the output channel
module cmbt_peak_checker import cmbt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_ready_i,
  input  wire logic              cmd_i,
  input  wire logic [COL_W-1:0]  column_i,
  input  wire logic [CHAN_W-1:0] blue_i,
  input  wire logic [CHAN_W-1:0] green_i,
  input  wire logic [CHAN_W-1:0] red_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_ready_i,
  input  wire logic [COL_W-1:0]  out_column_i,
  input  wire logic [CHAN_W-1:0] out_blue_i,
  input  wire logic [CHAN_W-1:0] out_green_i,
  input  wire logic [CHAN_W-1:0] out_red_i,
  input  wire logic              saturated_i,
  output int                     mismatches_o,
  output int                     outstanding_o
);

  logic [NORM_W-1:0]   peak_norm   [COLUMNS];
  logic [COLOUR_W-1:0] peak_colour [COLUMNS];
  result_t             striped_peaks_q [$];
  result_t             want;
  result_t             got;
  logic [NORM_W-1:0]   norm;
  int                  errors = 0;

  initial begin
    mismatches_o  = 0;
    outstanding_o = 0;
  end

  function automatic logic [NORM_W-1:0] brightness(input logic [CHAN_W-1:0] b,
                                                   input logic [CHAN_W-1:0] g,
                                                   input logic [CHAN_W-1:0] r);
    logic [NORM_W+1:0] sum;
    sum = b * b + g * g + r * r;
    return sum[NORM_W-1:0];
  endfunction

  function automatic result_t striped_peak(input logic [COL_W-1:0] col,
                                           input logic [COLOUR_W-1:0] colour);
    result_t res;
    res.column = col;
    res.blue   = colour[2*CHAN_W +: CHAN_W];
    res.green  = colour[CHAN_W +: CHAN_W];
    res.red    = colour[0 +: CHAN_W];
    res.sat    = (res.blue == SAT_LEVEL) || (res.green == SAT_LEVEL) ||
                 (res.red == SAT_LEVEL);
    if (res.sat) begin
      res.blue  = {CHAN_W{col[0]}};
      res.green = {CHAN_W{col[0]}};
      res.red   = {CHAN_W{col[0]}};
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < COLUMNS; i++) begin
        peak_norm[i]   = '0;
        peak_colour[i] = '0;
      end
      striped_peaks_q.delete();
      errors = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.column = out_column_i;
        got.blue   = out_blue_i;
        got.green  = out_green_i;
        got.red    = out_red_i;
        got.sat    = saturated_i;
        if (striped_peaks_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: col %0d bgr %02x %02x %02x sat %0b",
                     got.column, got.blue, got.green, got.red, got.sat);
        end else begin
          want = striped_peaks_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $write("mismatch: expected col %0d bgr %02x %02x %02x sat %0b, ",
                     want.column, want.blue, want.green, want.red, want.sat);
              $display("got col %0d bgr %02x %02x %02x sat %0b",
                       got.column, got.blue, got.green, got.red, got.sat);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (cmd_i == CMD_ACCUM) begin
          if (column_i < COLUMNS) begin
            norm = brightness(blue_i, green_i, red_i);
            if (norm > peak_norm[column_i]) begin
              peak_norm[column_i]   = norm;
              peak_colour[column_i] = {blue_i, green_i, red_i};
            end
          end
        end else begin
          if (column_i < COLUMNS) begin
            striped_peaks_q.push_back(striped_peak(column_i, peak_colour[column_i]));
            peak_norm[column_i]   = '0;
            peak_colour[column_i] = '0;
          end else begin
            striped_peaks_q.push_back('{column: column_i, blue: '0, green: '0,
                                        red: '0, sat: 1'b0});
          end
        end
      end
    end
    mismatches_o  = errors;
    outstanding_o = striped_peaks_q.size();
  end

endmodule

### bench/column_max_brightness_tracker_core_tb.sv
// testbench top: drives pixel and read transactions into the tracker and gives the verdict
module column_max_brightness_tracker_core_tb;
  import cmbt_pkg::*;

  localparam int HOLD_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int BURST_ITEMS    = 32;
  localparam int TAIL_ITEMS     = 100;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              cmd_i;
  logic [COL_W-1:0]  column_i;
  logic [CHAN_W-1:0] blue_i;
  logic [CHAN_W-1:0] green_i;
  logic [CHAN_W-1:0] red_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [COL_W-1:0]  out_column_o;
  logic [CHAN_W-1:0] out_blue_o;
  logic [CHAN_W-1:0] out_green_o;
  logic [CHAN_W-1:0] out_red_o;
  logic              saturated_o;

  int               mismatches;
  int               outstanding;
  int               accum_sent = 0;
  int               reads_sent = 0;
  int               idle_count = 0;
  bit               tx_idle_en = 1'b1;
  bit               rx_idle_en = 1'b1;
  bit               hold_req   = 1'b0;
  logic [COL_W-1:0] hot_cols [8];

  column_max_brightness_tracker_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .column_i     (column_i),
    .blue_i       (blue_i),
    .green_i      (green_i),
    .red_i        (red_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_column_o (out_column_o),
    .out_blue_o   (out_blue_o),
    .out_green_o  (out_green_o),
    .out_red_o    (out_red_o),
    .saturated_o  (saturated_o)
  );

  cmbt_peak_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .cmd_i         (cmd_i),
    .column_i      (column_i),
    .blue_i        (blue_i),
    .green_i       (green_i),
    .red_i         (red_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_column_i  (out_column_o),
    .out_blue_i    (out_blue_o),
    .out_green_i   (out_green_o),
    .out_red_i     (out_red_o),
    .saturated_i   (saturated_o),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    int stall_left;
    stall_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    while (idle_count < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_count = 0;
      else
        idle_count++;
    end
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  task automatic send_item(input cmd_e cmd, input logic [COL_W-1:0] col,
                           input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] g,
                           input logic [CHAN_W-1:0] r);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    column_i   <= col;
    blue_i     <= b;
    green_i    <= g;
    red_i      <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (cmd == CMD_READ)
      reads_sent++;
    else
      accum_sent++;
  endtask

  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 9))
      0:       return SAT_LEVEL;
      1:       return '0;
      2:       return CHAN_W'($urandom_range(0, 15));
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  task automatic pick_hot_cols();
    for (int i = 0; i < 8; i++) hot_cols[i] = COL_W'($urandom);
  endtask

  task automatic send_random();
    cmd_e             cmd;
    logic [COL_W-1:0] col;
    cmd = ($urandom_range(0, 3) == 0) ? CMD_READ : CMD_ACCUM;
    col = ($urandom_range(0, 9) < 7) ? hot_cols[$urandom_range(0, 7)] : COL_W'($urandom);
    send_item(cmd, col, rand_chan(), rand_chan(), rand_chan());
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    cmd_i       <= CMD_ACCUM;
    column_i    <= '0;
    blue_i      <= '0;
    green_i     <= '0;
    red_i       <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // cleared entries, dark pixel, ties and lower norms
    send_item(CMD_READ,  10'd0,    8'd0,   8'd0,   8'd0);
    send_item(CMD_ACCUM, 10'd0,    8'd0,   8'd0,   8'd0);
    send_item(CMD_READ,  10'd0,    8'd0,   8'd0,   8'd0);
    send_item(CMD_ACCUM, 10'd5,    8'd3,   8'd4,   8'd0);
    send_item(CMD_ACCUM, 10'd5,    8'd0,   8'd4,   8'd3);
    send_item(CMD_ACCUM, 10'd5,    8'd1,   8'd1,   8'd1);
    send_item(CMD_READ,  10'd5,    8'd255, 8'd255, 8'd255);
    send_item(CMD_READ,  10'd5,    8'd0,   8'd0,   8'd0);
    // saturated colours on odd and even columns
    send_item(CMD_ACCUM, 10'd1023, 8'd255, 8'd255, 8'd255);
    send_item(CMD_READ,  10'd1023, 8'd0,   8'd0,   8'd0);
    send_item(CMD_ACCUM, 10'd2,    8'd255, 8'd0,   8'd0);
    send_item(CMD_READ,  10'd2,    8'd0,   8'd0,   8'd0);
    send_item(CMD_ACCUM, 10'd7,    8'd0,   8'd255, 8'd0);
    send_item(CMD_ACCUM, 10'd7,    8'd0,   8'd0,   8'd255);
    send_item(CMD_READ,  10'd7,    8'd0,   8'd0,   8'd0);
    // brighter pixel replaces, near-saturated stays as is
    send_item(CMD_ACCUM, 10'd512,  8'd10,  8'd20,  8'd30);
    send_item(CMD_ACCUM, 10'd512,  8'd200, 8'd100, 8'd50);
    send_item(CMD_READ,  10'd512,  8'd0,   8'd0,   8'd0);
    send_item(CMD_ACCUM, 10'd341,  8'd170, 8'd85,  8'd254);
    send_item(CMD_READ,  10'd341,  8'd0,   8'd0,   8'd0);
    send_item(CMD_ACCUM, 10'd682,  8'd254, 8'd254, 8'd254);
    send_item(CMD_READ,  10'd682,  8'd0,   8'd0,   8'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 200 == 0) pick_hot_cols();
      send_random();
    end

    // long output stall while transactions keep coming
    tx_idle_en = 1'b0;
    hold_req   = 1'b1;
    for (int i = 0; i < BURST_ITEMS; i++) begin
      if (i % 2 == 0)
        send_item(CMD_READ, hot_cols[$urandom_range(0, 7)], '0, '0, '0);
      else
        send_random();
    end
    in_valid_i <= 1'b0;
    wait (outstanding == 0);
    @(posedge clk_i);

    rx_idle_en = 1'b0;
    for (int i = 0; i < TAIL_ITEMS; i++) send_random();
    in_valid_i <= 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d pixel and %0d read transactions with random gaps and a %0d-cycle stall",
             accum_sent, reads_sent, HOLD_CYCLES);
    $display("mismatches counted: %0d", mismatches);
    if (mismatches == 0 && outstanding == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
